// ===== design/floor_ceiling_texel_caster_defines.svh =====
// ---------------------------------------------------------------------------
// Floor/ceiling texel caster assertion macros
// Concurrent check helpers shared by the caster RTL; ASSERT_OFF strips them.
// ---------------------------------------------------------------------------
`ifndef FLOOR_CEILING_TEXEL_CASTER_DEFINES_SVH
`define FLOOR_CEILING_TEXEL_CASTER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcc assertion failed");
// next-cycle implication
`define FCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcc assertion failed");
`else
`define FCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/fcc_pkg.sv =====
// ---------------------------------------------------------------------------
// Floor/ceiling texel caster package
// Shared widths, register indexes, request and configuration types.
// ---------------------------------------------------------------------------
package fcc_pkg;

    localparam int TEX_WIDTH  = 64;
    localparam int TEX_HEIGHT = 64;
    localparam int MAX_WIN    = 2048;

    localparam int TEX_DEPTH = 4096;
    localparam int TEX_AW    = 12;
    localparam int COLOR_W   = 24;
    localparam int DARK_W    = 23;
    localparam logic [DARK_W-1:0] DARK_MASK = 23'h7F7F7F;

    localparam int ROW_W   = 11;
    localparam int DIM_W   = $clog2(MAX_WIN + 1);
    localparam int P_W     = DIM_W - 1;
    localparam int W_W     = DIM_W;
    localparam int DEN_W   = P_W + W_W;
    localparam int R0_W    = 17;
    localparam int AX_W    = R0_W + W_W + 1;
    localparam int BX_W    = ROW_W + 1 + 16;
    localparam int N_W     = AX_W + 1;
    localparam int NN_W    = N_W + DIM_W + 2;
    localparam int NUM_W   = NN_W - 1;
    localparam int FRAC_W  = 16;
    localparam int COORD_W = 9;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] REG_POS_X   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DIR_X   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PLANE_X = 3'd4;
    localparam logic [CFG_IW-1:0] REG_PLANE_Y = 3'd5;
    localparam logic [CFG_IW-1:0] REG_WIN_W   = 3'd6;
    localparam logic [CFG_IW-1:0] REG_WIN_H   = 3'd7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;
    localparam logic SEL_FLOOR = 1'b0;
    localparam logic SEL_CEIL  = 1'b1;

    typedef struct packed {
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic [11:0]        win_w;
        logic [11:0]        win_h;
    } cfg_t;

    // request fields riding alongside the arithmetic
    typedef struct packed {
        logic               valid;
        logic               op;
        logic               sel;
        logic [TEX_AW-1:0]  idx;
        logic [COLOR_W-1:0] color;
        logic [ROW_W-1:0]   row;
        logic [ROW_W-1:0]   col;
        logic [ROW_W-1:0]   ceil_row;
        logic               err;
    } side_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic             neg;
    } div_lane_t;

endpackage

// ===== design/fcc_front.sv =====
// ---------------------------------------------------------------------------
// Caster front end
// Row checks, ray products, the dividend as sign and magnitude, and the divisor, five stages.
// ---------------------------------------------------------------------------
module fcc_front
    import fcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  side_t            side_in,
    input  cfg_t             cfg,
    output side_t            side_out,
    output logic             neg_x,
    output logic             neg_y,
    output logic [NUM_W-1:0] mag_x,
    output logic [NUM_W-1:0] mag_y,
    output logic [DEN_W-1:0] den
);

    logic [12:0]      h13;
    logic [12:0]      w13;
    logic [12:0]      half13;
    logic [12:0]      row13;
    logic [DIM_W-1:0] h_clamp;
    logic [DIM_W-1:0] w_clamp;
    logic             err;
    side_t            s1_next;

    side_t            s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic [DIM_W-1:0] s1_h_reg, s2_h_reg, s3_h_reg;
    logic [W_W-1:0]   s1_w_reg;
    logic [P_W-1:0]   s1_p_reg;

    logic signed [R0_W-1:0] r0x, r0y;
    logic signed [AX_W-1:0] ax_next, ay_next, s2_ax_reg, s2_ay_reg;
    logic signed [BX_W-1:0] bx_next, by_next, s2_bx_reg, s2_by_reg;
    logic signed [N_W-1:0]  nx_next, ny_next, s3_nx_reg, s3_ny_reg;
    logic signed [NN_W-1:0] nnx_next, nny_next, s4_nnx_reg, s4_nny_reg;
    logic [DEN_W-1:0]       den_next, s2_den_reg, s3_den_reg, s4_den_reg, s5_den_reg;
    logic                   s5_negx_reg, s5_negy_reg;
    logic [NUM_W-1:0]       s5_magx_reg, s5_magy_reg;

    // stage 1: clamp screen size, range check, mirrored ceiling row
    always_comb
    begin
        h13     = {1'b0, cfg.win_h};
        w13     = {1'b0, cfg.win_w};
        h_clamp = (h13 > 13'(MAX_WIN)) ? DIM_W'(MAX_WIN) : DIM_W'(cfg.win_h);
        w_clamp = (w13 > 13'(MAX_WIN)) ? DIM_W'(MAX_WIN) : DIM_W'(cfg.win_w);
        if (w_clamp == '0)
        begin
            w_clamp = DIM_W'(1);
        end
        half13 = 13'(h_clamp) >> 1;
        row13  = 13'(side_in.row);
        err    = (row13 <= half13) || (row13 >= 13'(h_clamp));
        s1_next          = side_in;
        s1_next.err      = err;
        s1_next.ceil_row = err ? '0 : ROW_W'(13'(h_clamp) - row13 - 13'd1);
    end

    // stage 2: products
    always_comb
    begin
        r0x      = R0_W'(cfg.dir_x) - R0_W'(cfg.plane_x);
        r0y      = R0_W'(cfg.dir_y) - R0_W'(cfg.plane_y);
        ax_next  = r0x * $signed({1'b0, s1_w_reg});
        ay_next  = r0y * $signed({1'b0, s1_w_reg});
        bx_next  = $signed({1'b0, s1_reg.col}) * cfg.plane_x;
        by_next  = $signed({1'b0, s1_reg.col}) * cfg.plane_y;
        den_next = (s1_reg.op == OP_CAST && !s1_reg.err) ? s1_p_reg * s1_w_reg
                                                          : DEN_W'(1);
    end

    // stage 3: n = r0*w + 2*col*plane
    always_comb
    begin
        nx_next = {{(N_W-AX_W){s2_ax_reg[AX_W-1]}}, s2_ax_reg}
                + {{(N_W-BX_W-1){s2_bx_reg[BX_W-1]}}, s2_bx_reg, 1'b0};
        ny_next = {{(N_W-AX_W){s2_ay_reg[AX_W-1]}}, s2_ay_reg}
                + {{(N_W-BX_W-1){s2_by_reg[BX_W-1]}}, s2_by_reg, 1'b0};
    end

    // stage 4: dividend 2*h*n
    always_comb
    begin
        nnx_next = s3_nx_reg * $signed({1'b0, s3_h_reg, 1'b0});
        nny_next = s3_ny_reg * $signed({1'b0, s3_h_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
            s5_reg <= s4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_h_reg    <= h_clamp;
            s1_w_reg    <= w_clamp;
            s1_p_reg    <= P_W'(row13 - half13);
            s2_h_reg    <= s1_h_reg;
            s2_ax_reg   <= ax_next;
            s2_ay_reg   <= ay_next;
            s2_bx_reg   <= bx_next;
            s2_by_reg   <= by_next;
            s2_den_reg  <= den_next;
            s3_h_reg    <= s2_h_reg;
            s3_nx_reg   <= nx_next;
            s3_ny_reg   <= ny_next;
            s3_den_reg  <= s2_den_reg;
            s4_nnx_reg  <= nnx_next;
            s4_nny_reg  <= nny_next;
            s4_den_reg  <= s3_den_reg;
            s5_negx_reg <= s4_nnx_reg[NN_W-1];
            s5_negy_reg <= s4_nny_reg[NN_W-1];
            s5_magx_reg <= s4_nnx_reg[NN_W-1] ? NUM_W'(-s4_nnx_reg) : NUM_W'(s4_nnx_reg);
            s5_magy_reg <= s4_nny_reg[NN_W-1] ? NUM_W'(-s4_nny_reg) : NUM_W'(s4_nny_reg);
            s5_den_reg  <= s4_den_reg;
        end
    end

    assign side_out = s5_reg;
    assign neg_x    = s5_negx_reg;
    assign neg_y    = s5_negy_reg;
    assign mag_x    = s5_magx_reg;
    assign mag_y    = s5_magy_reg;
    assign den      = s5_den_reg;

endmodule

// ===== design/fcc_divider.sv =====
// ---------------------------------------------------------------------------
// Caster divider
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module fcc_divider
    import fcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  side_t             side_in,
    input  logic              neg_x,
    input  logic              neg_y,
    input  logic [NUM_W-1:0]  mag_x,
    input  logic [NUM_W-1:0]  mag_y,
    input  logic [DEN_W-1:0]  den,
    output side_t             side_out,
    output logic [FRAC_W-1:0] q_x,
    output logic [FRAC_W-1:0] q_y,
    output logic              rnz_x,
    output logic              rnz_y,
    output logic              qneg_x,
    output logic              qneg_y
);

    function automatic div_lane_t div_step(div_lane_t src, logic [DEN_W-1:0] d);
        logic [DEN_W:0] trial;
        logic           ge;
        div_lane_t      res;
        trial   = {src.rem, src.num[NUM_W-1]};
        ge      = trial >= {1'b0, d};
        res.rem = ge ? DEN_W'(trial - {1'b0, d}) : DEN_W'(trial);
        res.num = {src.num[NUM_W-2:0], ge};
        res.neg = src.neg;
        return res;
    endfunction

    side_t            side_reg [NUM_W];
    div_lane_t        lx_reg   [NUM_W];
    div_lane_t        ly_reg   [NUM_W];
    logic [DEN_W-1:0] den_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        side_t            side_src;
        div_lane_t        lx_src, ly_src;
        logic [DEN_W-1:0] den_src;

        if (k == 0)
        begin : g_first
            assign side_src = side_in;
            assign lx_src   = '{rem: '0, num: mag_x, neg: neg_x};
            assign ly_src   = '{rem: '0, num: mag_y, neg: neg_y};
            assign den_src  = den;
        end
        else
        begin : g_next
            assign side_src = side_reg[k-1];
            assign lx_src   = lx_reg[k-1];
            assign ly_src   = ly_reg[k-1];
            assign den_src  = den_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else if (en)
            begin
                side_reg[k] <= side_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lx_reg[k]  <= div_step(lx_src, den_src);
                ly_reg[k]  <= div_step(ly_src, den_src);
                den_reg[k] <= den_src;
            end
        end
    end

    assign side_out = side_reg[NUM_W-1];
    assign q_x      = lx_reg[NUM_W-1].num[FRAC_W-1:0];
    assign q_y      = ly_reg[NUM_W-1].num[FRAC_W-1:0];
    assign rnz_x    = lx_reg[NUM_W-1].rem != '0;
    assign rnz_y    = ly_reg[NUM_W-1].rem != '0;
    assign qneg_x   = lx_reg[NUM_W-1].neg;
    assign qneg_y   = ly_reg[NUM_W-1].neg;

endmodule

// ===== design/fcc_texture.sv =====
// ---------------------------------------------------------------------------
// Caster texture stage
// Floor point fraction, texel address, and the two texture memories.
// ---------------------------------------------------------------------------
module fcc_texture
    import fcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  cfg_t               cfg,
    input  side_t              side_in,
    input  logic [FRAC_W-1:0]  q_x,
    input  logic [FRAC_W-1:0]  q_y,
    input  logic               rnz_x,
    input  logic               rnz_y,
    input  logic               qneg_x,
    input  logic               qneg_y,
    output side_t              side_out,
    output logic [COLOR_W-1:0] floor_rd,
    output logic [COLOR_W-1:0] ceil_rd
);

    side_t              s6_reg, s7_reg, s8_reg;
    logic [FRAC_W-1:0]  qlx, qly;
    logic [FRAC_W-1:0]  s6_fx_reg, s6_fy_reg;
    logic [FRAC_W+8:0]  px, py;
    logic [COORD_W-1:0] tcx, tcy;
    logic [17:0]        addr_full;
    logic [TEX_AW-1:0]  s7_addr_reg;
    logic [COLOR_W-1:0] floor_mem [TEX_DEPTH];
    logic [COLOR_W-1:0] ceil_mem  [TEX_DEPTH];
    logic [COLOR_W-1:0] floor_rd_reg, ceil_rd_reg;

    // floor of a negative quotient: -(Q + 1) when a remainder is left
    always_comb
    begin
        qlx = qneg_x ? FRAC_W'(-(q_x + FRAC_W'(rnz_x))) : q_x;
        qly = qneg_y ? FRAC_W'(-(q_y + FRAC_W'(rnz_y))) : q_y;
    end

    always_comb
    begin
        px  = (FRAC_W+9)'(s6_fx_reg) * (FRAC_W+9)'(TEX_WIDTH);
        py  = (FRAC_W+9)'(s6_fy_reg) * (FRAC_W+9)'(TEX_HEIGHT);
        tcx = COORD_W'(px >> FRAC_W) & COORD_W'(TEX_WIDTH - 1);
        tcy = COORD_W'(py >> FRAC_W) & COORD_W'(TEX_HEIGHT - 1);
        addr_full = 18'(TEX_WIDTH) * 18'(tcy) + 18'(tcx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_reg <= '0;
            s7_reg <= '0;
            s8_reg <= '0;
        end
        else if (en)
        begin
            s6_reg <= side_in;
            s7_reg <= s6_reg;
            s8_reg <= s7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_fx_reg   <= cfg.pos_x[FRAC_W-1:0] + qlx;
            s6_fy_reg   <= cfg.pos_y[FRAC_W-1:0] + qly;
            s7_addr_reg <= addr_full[TEX_AW-1:0];
        end
    end

    // writes and reads meet here, in request order
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s7_reg.valid && s7_reg.op == OP_WRITE)
            begin
                if (s7_reg.sel == SEL_FLOOR)
                begin
                    floor_mem[s7_reg.idx] <= s7_reg.color;
                end
                else
                begin
                    ceil_mem[s7_reg.idx] <= s7_reg.color;
                end
            end
            floor_rd_reg <= floor_mem[s7_addr_reg];
            ceil_rd_reg  <= ceil_mem[s7_addr_reg];
        end
    end

    assign side_out = s8_reg;
    assign floor_rd = floor_rd_reg;
    assign ceil_rd  = ceil_rd_reg;

endmodule

// ===== design/floor_ceiling_texel_caster.sv =====
// ---------------------------------------------------------------------------
// Floor/ceiling texel caster
// Casts one floor pixel and its mirrored ceiling pixel per request, and
// stores texels into the floor and ceiling textures.
//
//   channel  valid      stall      payload
//   in       in_valid   in_stall   op tex_select texel_index texel_color row column
//   out      out_valid  out_stall  floor/ceiling colors, rows, out_column, row_error
//   cfg      cfg_we     -          cfg_index cfg_data
//
// One request per cycle while not stalled; front, divider, texture and output
// stages follow in turn. The 44-stage divider pipeline sets the depth.
// Reset clears valid bits, sets config defaults; data and textures stay undefined.
// A stalled result freezes the whole pipeline, in_stall follows at once.
// ---------------------------------------------------------------------------
`include "floor_ceiling_texel_caster_defines.svh"

module floor_ceiling_texel_caster
    import fcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic                tex_select,
    input  logic [TEX_AW-1:0]   texel_index,
    input  logic [COLOR_W-1:0]  texel_color,
    input  logic [ROW_W-1:0]    row,
    input  logic [ROW_W-1:0]    column,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DARK_W-1:0]   floor_color,
    output logic [DARK_W-1:0]   ceiling_color,
    output logic [ROW_W-1:0]    floor_row,
    output logic [ROW_W-1:0]    ceiling_row,
    output logic [ROW_W-1:0]    out_column,
    output logic                row_error
);

    cfg_t               cfg_reg;
    logic               en;
    side_t              side_in;
    side_t              fr_side, dv_side, tx_side;
    logic               fr_negx, fr_negy;
    logic [NUM_W-1:0]   fr_magx, fr_magy;
    logic [DEN_W-1:0]   fr_den;
    logic [FRAC_W-1:0]  dv_qx, dv_qy;
    logic               dv_rnzx, dv_rnzy, dv_negx, dv_negy;
    logic [COLOR_W-1:0] floor_rd, ceil_rd;
    logic               out_valid_reg;
    logic [DARK_W-1:0]  floor_color_reg, ceiling_color_reg;
    logic [ROW_W-1:0]   floor_row_reg, ceiling_row_reg, out_column_reg;
    logic               row_error_reg;
    logic [12:0]        h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x   <= 32'd131072;
            cfg_reg.pos_y   <= 32'd131072;
            cfg_reg.dir_x   <= -16'sd16384;
            cfg_reg.dir_y   <= 16'sd0;
            cfg_reg.plane_x <= 16'sd0;
            cfg_reg.plane_y <= 16'sd10813;
            cfg_reg.win_w   <= 12'd640;
            cfg_reg.win_h   <= 12'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POS_X:   cfg_reg.pos_x   <= cfg_data;
                REG_POS_Y:   cfg_reg.pos_y   <= cfg_data;
                REG_DIR_X:   cfg_reg.dir_x   <= cfg_data[15:0];
                REG_DIR_Y:   cfg_reg.dir_y   <= cfg_data[15:0];
                REG_PLANE_X: cfg_reg.plane_x <= cfg_data[15:0];
                REG_PLANE_Y: cfg_reg.plane_y <= cfg_data[15:0];
                REG_WIN_W:   cfg_reg.win_w   <= cfg_data[11:0];
                REG_WIN_H:   cfg_reg.win_h   <= cfg_data[11:0];
                default:     ;
            endcase
        end
    end

    // pipeline advances unless a finished result is held
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        side_in          = '0;
        side_in.valid    = in_valid;
        side_in.op       = op;
        side_in.sel      = tex_select;
        side_in.idx      = texel_index;
        side_in.color    = texel_color;
        side_in.row      = row;
        side_in.col      = column;
    end

    fcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (side_in),
        .cfg      (cfg_reg),
        .side_out (fr_side),
        .neg_x    (fr_negx),
        .neg_y    (fr_negy),
        .mag_x    (fr_magx),
        .mag_y    (fr_magy),
        .den      (fr_den)
    );

    fcc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .side_in  (fr_side),
        .neg_x    (fr_negx),
        .neg_y    (fr_negy),
        .mag_x    (fr_magx),
        .mag_y    (fr_magy),
        .den      (fr_den),
        .side_out (dv_side),
        .q_x      (dv_qx),
        .q_y      (dv_qy),
        .rnz_x    (dv_rnzx),
        .rnz_y    (dv_rnzy),
        .qneg_x   (dv_negx),
        .qneg_y   (dv_negy)
    );

    fcc_texture u_texture (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .side_in  (dv_side),
        .q_x      (dv_qx),
        .q_y      (dv_qy),
        .rnz_x    (dv_rnzx),
        .rnz_y    (dv_rnzy),
        .qneg_x   (dv_negx),
        .qneg_y   (dv_negy),
        .side_out (tx_side),
        .floor_rd (floor_rd),
        .ceil_rd  (ceil_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= tx_side.valid && tx_side.op == OP_CAST;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            floor_color_reg   <= tx_side.err ? '0 : floor_rd[COLOR_W-1:1] & DARK_MASK;
            ceiling_color_reg <= tx_side.err ? '0 : ceil_rd[COLOR_W-1:1] & DARK_MASK;
            floor_row_reg     <= tx_side.row;
            ceiling_row_reg   <= tx_side.ceil_row;
            out_column_reg    <= tx_side.col;
            row_error_reg     <= tx_side.err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign floor_color   = floor_color_reg;
    assign ceiling_color = ceiling_color_reg;
    assign floor_row     = floor_row_reg;
    assign ceiling_row   = ceiling_row_reg;
    assign out_column    = out_column_reg;
    assign row_error     = row_error_reg;

    assign h_eff = ({1'b0, cfg_reg.win_h} > 13'(MAX_WIN)) ? 13'(MAX_WIN)
                                                           : {1'b0, cfg_reg.win_h};

    `FCC_ASSERT_IMPL(a_error_blanks, clk, rst_n, out_valid && row_error, (floor_color == '0) && (ceiling_color == '0) && (ceiling_row == '0))
    `FCC_ASSERT_IMPL(a_ceiling_mirror, clk, rst_n, out_valid && !row_error, (13'(floor_row) + 13'(ceiling_row) + 13'd1) == h_eff)
    `FCC_ASSERT_NEXT(a_held_result, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_column) && $stable(floor_color))

endmodule
